[src/radial_glow_pixel_generator_core_macros.svh]
// Assertion macros used by the radial glow pixel generator top level.
`ifndef RADIAL_GLOW_PIXEL_GENERATOR_CORE_MACROS_SVH
`define RADIAL_GLOW_PIXEL_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication.
`define RGPG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RGPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/rgpg_pkg.sv]
// Types and constants of the radial glow pixel generator.
`default_nettype none

package rgpg_pkg;

   localparam int MAX_SIDE    = 1024;
   localparam int SIDE_W      = 11;
   localparam int COORD_W     = 10;
   localparam int LEVEL_W     = 8;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int DIST_W      = SQ_W + 1;
   localparam int GLOW_SCALE  = 65025;
   localparam int SCALE_W     = 16;
   localparam int TARGET_W    = DIST_W + SCALE_W;
   localparam int RAD_W       = TARGET_W + (TARGET_W % 2);
   localparam int SQRT_STEPS  = RAD_W / 2;
   localparam int REM_W       = SQRT_STEPS + 2;
   localparam int ROOT_W      = SQRT_STEPS;
   localparam int QUOT_STEPS  = LEVEL_W;
   localparam int ACC_W       = COORD_W + LEVEL_W;
   localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;

   localparam int DIST_STAGES  = 4;
   localparam int QUOT_STAGES  = QUOT_STEPS + 1;
   localparam int SHADE_STAGES = 2;
   localparam int LATENCY      = DIST_STAGES + SQRT_STEPS + QUOT_STAGES + SHADE_STAGES;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = SIDE_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_TINT_RED     = 3'd2,
      CSR_TINT_GREEN   = 3'd3,
      CSR_TINT_BLUE    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] alpha;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  image_width;
      logic [SIDE_W-1:0]  image_height;
      logic [LEVEL_W-1:0] tint_red;
      logic [LEVEL_W-1:0] tint_green;
      logic [LEVEL_W-1:0] tint_blue;
   } cfg_type;

endpackage

`default_nettype wire

[src/radial_glow_pixel_generator_core.sv]
// Top level of the radial glow pixel generator: register file and pixel pipeline.
`default_nettype none

`include "radial_glow_pixel_generator_core_macros.svh"

// Radial glow pixel generator. Each request carries one pixel coordinate
// (column, row); at the end of the pipeline the block returns that pixel's alpha
// and tinted red/green/blue for one cycle on rsp_data, marked by rsp_strobe.
// A new request may be issued on every clock while busy is low, so the block
// sustains one pixel per cycle; the path holds distance and scaling stages,
// the 19-stage square-root pipeline (one root bit per stage), the 8-stage
// restoring quotient against the glow radius and shading stages. There is no
// backpressure: results must be taken in the cycle they appear. busy is high
// only in the first cycle after reset. Registers (sprite size, tint) must be
// written only when no request is in flight; they feed all but the root directly.
module radial_glow_pixel_generator_core
   import rgpg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   // response channel
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                busy_ff;
   logic                req_accept;
   logic                csr_write;
   cfg_type             cfg_ff, cfg_in;
   logic [SIDE_W-1:0]   side_sat;

   // pipeline links
   logic                dist_valid;
   logic [TARGET_W-1:0] dist_target;
   logic                sqrt_valid;
   logic [ROOT_W-1:0]   sqrt_root;
   logic                sqrt_inexact;
   logic                quot_valid;
   logic [LEVEL_W-1:0]  quot_below;
   logic                quot_center;

   assign req_accept = start && !busy_ff;
   assign csr_ready  = !busy_ff;
   assign csr_write  = csr_valid && csr_ready;
   assign busy       = busy_ff;

   // oversized sides clamp to the largest sprite
   assign side_sat = (csr_wdata > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : csr_wdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = side_sat;
            CSR_IMAGE_HEIGHT: cfg_in.image_height = side_sat;
            CSR_TINT_RED:     cfg_in.tint_red     = csr_wdata[LEVEL_W-1:0];
            CSR_TINT_GREEN:   cfg_in.tint_green   = csr_wdata[LEVEL_W-1:0];
            CSR_TINT_BLUE:    cfg_in.tint_blue    = csr_wdata[LEVEL_W-1:0];
            default:          cfg_in = cfg_ff;  // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff             <= 1'b1;
         cfg_ff.image_width  <= SIDE_W'(32);
         cfg_ff.image_height <= SIDE_W'(32);
         cfg_ff.tint_red     <= LEVEL_W'(LEVEL_MAX);
         cfg_ff.tint_green   <= LEVEL_W'(LEVEL_MAX);
         cfg_ff.tint_blue    <= LEVEL_W'(LEVEL_MAX);
      end else begin
         busy_ff <= 1'b0;
         cfg_ff  <= cfg_in;
      end
   end

   // D = dx^2 + dy^2, then T = 65025 * D
   rgpg_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_accept),
      .in_req     (req_data),
      .out_valid  (dist_valid),
      .out_target (dist_target)
   );

   // floor(sqrt(T)) and whether T was a perfect square
   rgpg_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dist_valid),
      .in_target   (dist_target),
      .out_valid   (sqrt_valid),
      .out_root    (sqrt_root),
      .out_inexact (sqrt_inexact)
   );

   // smallest m with m*L >= ceil(sqrt(T)), found as largest p with p*L below it
   rgpg_quot u_quot (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (sqrt_valid),
      .in_root    (sqrt_root),
      .in_inexact (sqrt_inexact),
      .out_valid  (quot_valid),
      .out_below  (quot_below),
      .out_center (quot_center)
   );

   // intensity, tint products; its output register drives the response ports
   rgpg_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (quot_valid),
      .in_below  (quot_below),
      .in_center (quot_center),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

   // every response stems from a request exactly one pipeline depth earlier
   `RGPG_ASSERT_NOW(a_rsp_from_req, clock, reset, rsp_strobe, $past(req_accept, LATENCY), "response without matching request")

   // a dark pixel carries no color whatever the tint
   `RGPG_ASSERT_NOW(a_dark_no_color, clock, reset, rsp_strobe && (rsp_data.alpha == '0), (rsp_data.red == '0) && (rsp_data.green == '0) && (rsp_data.blue == '0), "color on a zero-alpha pixel")

   // oversized width write lands clamped
   `RGPG_ASSERT_NEXT(a_width_clamped, clock, reset, csr_write && (csr_index == CSR_IMAGE_WIDTH) && (csr_wdata > SIDE_W'(MAX_SIDE)), cfg_ff.image_width == SIDE_W'(MAX_SIDE), "image width not clamped")

endmodule

`default_nettype wire

[src/rgpg_dist.sv]
// Squared distance to the sprite center, scaled by 255 squared.
`default_nettype none

module rgpg_dist
   import rgpg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   input  req_type             in_req,
   output logic                out_valid,
   output logic [TARGET_W-1:0] out_target
);

   logic [COORD_W-1:0]     cx;
   logic [COORD_W-1:0]     cy;
   logic [DIST_STAGES-1:0] valid_ff, valid_in;
   logic [COORD_W-1:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]        dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [DIST_W-1:0]      d_ff, d_in;
   logic [TARGET_W-1:0]    t_ff, t_in;

   assign cx = cfg.image_width[SIDE_W-1:1];
   assign cy = cfg.image_height[SIDE_W-1:1];

   always_comb begin
      valid_in = {valid_ff[DIST_STAGES-2:0], in_valid};
      dx_in    = (cx >= in_req.column) ? cx - in_req.column : in_req.column - cx;
      dy_in    = (cy >= in_req.row) ? cy - in_req.row : in_req.row - cy;
      dx2_in   = SQ_W'(dx_ff) * SQ_W'(dx_ff);
      dy2_in   = SQ_W'(dy_ff) * SQ_W'(dy_ff);
      d_in     = DIST_W'(dx2_ff) + DIST_W'(dy2_ff);
      t_in     = TARGET_W'(d_ff) * TARGET_W'(GLOW_SCALE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      dx2_ff <= dx2_in;
      dy2_ff <= dy2_in;
      d_ff   <= d_in;
      t_ff   <= t_in;
   end

   assign out_valid  = valid_ff[DIST_STAGES-1];
   assign out_target = t_ff;

endmodule

`default_nettype wire

[src/rgpg_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module rgpg_sqrt
   import rgpg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [TARGET_W-1:0] in_target,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output logic                out_inexact
);

   logic [SQRT_STEPS-1:0] valid_ff;
   logic [REM_W-1:0]      rem_ff  [SQRT_STEPS];
   logic [ROOT_W-1:0]     root_ff [SQRT_STEPS];
   logic [RAD_W-1:0]      rad_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic               valid_i;
      logic [REM_W-1:0]   rem_i, rem_in;
      logic [ROOT_W-1:0]  root_i, root_in;
      logic [RAD_W-1:0]   rad_i, rad_in;
      logic [REM_W+1:0]   rem_sh;
      logic [REM_W+1:0]   trial;

      if (k == 0) begin : g_first
         assign valid_i = in_valid;
         assign rem_i   = '0;
         assign root_i  = '0;
         assign rad_i   = RAD_W'(in_target);
      end else begin : g_next
         assign valid_i = valid_ff[k-1];
         assign rem_i   = rem_ff[k-1];
         assign root_i  = root_ff[k-1];
         assign rad_i   = rad_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_i, rad_i[RAD_W-1:RAD_W-2]};
         trial  = {2'b00, root_i, 2'b01};
         rad_in = {rad_i[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_i[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_i[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_i;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_in;
      end
   end

   assign out_valid   = valid_ff[SQRT_STEPS-1];
   assign out_root    = root_ff[SQRT_STEPS-1];
   assign out_inexact = |rem_ff[SQRT_STEPS-1];

endmodule

`default_nettype wire

[src/rgpg_quot.sv]
// Ceiling quotient of the scaled distance by the radius, restoring one bit per stage.
`default_nettype none

module rgpg_quot
   import rgpg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic [ROOT_W-1:0]  in_root,
   input  logic               in_inexact,
   output logic               out_valid,
   output logic [LEVEL_W-1:0] out_below,
   output logic               out_center
);

   // ceil(sqrt) fits the root width: the largest root is well below its top value
   logic [SIDE_W-1:0]     side_min;
   logic [COORD_W-1:0]    len;
   logic                  c_valid_ff;
   logic [ROOT_W-1:0]     c_ff, c_in;
   logic                  czero_ff, czero_in;

   logic [QUOT_STEPS-1:0] valid_ff;
   logic [ACC_W-1:0]      acc_ff   [QUOT_STEPS];
   logic [LEVEL_W-1:0]    p_ff     [QUOT_STEPS];
   logic [ROOT_W-1:0]     cq_ff    [QUOT_STEPS];
   logic                  zq_ff    [QUOT_STEPS];

   assign side_min = (cfg.image_width < cfg.image_height) ? cfg.image_width
                                                          : cfg.image_height;
   assign len      = side_min[SIDE_W-1:1];

   always_comb begin
      c_in     = in_root + ROOT_W'(in_inexact);
      czero_in = (in_root == '0) && !in_inexact;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= in_valid;
      end
      c_ff     <= c_in;
      czero_ff <= czero_in;
   end

   // stage j decides bit (QUOT_STEPS-1-j) of the largest p with p*len < c
   for (genvar j = 0; j < QUOT_STEPS; j++) begin : g_step
      logic               valid_i;
      logic [ACC_W-1:0]   acc_i, acc_in;
      logic [LEVEL_W-1:0] p_i, p_in;
      logic [ROOT_W-1:0]  c_i;
      logic               z_i;
      logic [ACC_W-1:0]   trial;

      if (j == 0) begin : g_first
         assign valid_i = c_valid_ff;
         assign acc_i   = '0;
         assign p_i     = '0;
         assign c_i     = c_ff;
         assign z_i     = czero_ff;
      end else begin : g_next
         assign valid_i = valid_ff[j-1];
         assign acc_i   = acc_ff[j-1];
         assign p_i     = p_ff[j-1];
         assign c_i     = cq_ff[j-1];
         assign z_i     = zq_ff[j-1];
      end

      always_comb begin
         trial = acc_i + (ACC_W'(len) << (QUOT_STEPS - 1 - j));
         if (ROOT_W'(trial) < c_i) begin
            acc_in = trial;
            p_in   = p_i | (LEVEL_W'(1) << (QUOT_STEPS - 1 - j));
         end else begin
            acc_in = acc_i;
            p_in   = p_i;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= valid_i;
         end
         acc_ff[j] <= acc_in;
         p_ff[j]   <= p_in;
         cq_ff[j]  <= c_i;
         zq_ff[j]  <= z_i;
      end
   end

   assign out_valid  = valid_ff[QUOT_STEPS-1];
   assign out_below  = p_ff[QUOT_STEPS-1];
   assign out_center = zq_ff[QUOT_STEPS-1];

endmodule

`default_nettype wire

[src/rgpg_shade.sv]
// Intensity from the quotient, then alpha and tinted color channels.
`default_nettype none

module rgpg_shade
   import rgpg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  logic [LEVEL_W-1:0] in_below,
   input  logic               in_center,
   output logic               out_valid,
   output rsp_type            out_rsp
);

   logic                   inten_valid_ff;
   logic [LEVEL_W-1:0]     inten_ff, inten_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;
   logic [2*LEVEL_W-1:0]   prod_r, prod_g, prod_b;

   always_comb begin
      // zero distance: full intensity; no m in range: dark; else 255 - (p + 1)
      if (in_center) begin
         inten_in = LEVEL_W'(LEVEL_MAX);
      end else if (in_below == LEVEL_W'(LEVEL_MAX)) begin
         inten_in = '0;
      end else begin
         inten_in = LEVEL_W'(LEVEL_MAX - 1) - in_below;
      end

      prod_r       = (2*LEVEL_W)'(inten_ff) * (2*LEVEL_W)'(cfg.tint_red);
      prod_g       = (2*LEVEL_W)'(inten_ff) * (2*LEVEL_W)'(cfg.tint_green);
      prod_b       = (2*LEVEL_W)'(inten_ff) * (2*LEVEL_W)'(cfg.tint_blue);
      rsp_in.alpha = inten_ff;
      rsp_in.red   = prod_r[2*LEVEL_W-1:LEVEL_W];
      rsp_in.green = prod_g[2*LEVEL_W-1:LEVEL_W];
      rsp_in.blue  = prod_b[2*LEVEL_W-1:LEVEL_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inten_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         inten_valid_ff <= in_valid;
         rsp_valid_ff   <= inten_valid_ff;
      end
      inten_ff <= inten_in;
      rsp_ff   <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire
